// File: design/bbcwd_pkg.sv
// types and constants shared by the write directory files
package bbcwd_pkg;

	localparam int DEV_W      = 4;
	localparam int BLK_W      = 16;
	localparam int OUT_SLOT_W = 4;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_CLOSED    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_VICTIM = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WRITE_POLICY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_POLICY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CACHE_CLOSED   = 2'd2;

	// tag and dirty flag of one cached block
	typedef struct packed {
		logic [DEV_W-1:0] dev;
		logic [BLK_W-1:0] blk;
		logic             dirty;
	} entry_t;

	// per-cycle command broadcast to the cell row
	typedef struct packed {
		logic shift;
		logic load_match;
	} cell_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic                  hit;
		logic                  slot_valid;
		logic [OUT_SLOT_W-1:0] slot;
		logic                  write_to_disk;
		logic                  evict_writeback;
		logic [DEV_W-1:0]      evicted_device;
		logic [BLK_W-1:0]      evicted_block;
		logic [OUT_SLOT_W-1:0] evicted_slot;
	} rsp_t;

endpackage

// File: design/bbcwd_ifs.sv
// handshake channel interfaces: write request, directory response, register write
interface bbcwd_req_if;
	logic                        valid;
	logic                        ready;
	logic [bbcwd_pkg::DEV_W-1:0] device_id;
	logic [bbcwd_pkg::BLK_W-1:0] block_number;

	modport source (output valid, device_id, block_number, input ready);
	modport sink (input valid, device_id, block_number, output ready);
endinterface

interface bbcwd_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [bbcwd_pkg::STATUS_W-1:0]   status;
	logic                             hit;
	logic                             slot_valid;
	logic [bbcwd_pkg::OUT_SLOT_W-1:0] slot;
	logic                             write_to_disk;
	logic                             evict_writeback;
	logic [bbcwd_pkg::DEV_W-1:0]      evicted_device;
	logic [bbcwd_pkg::BLK_W-1:0]      evicted_block;
	logic [bbcwd_pkg::OUT_SLOT_W-1:0] evicted_slot;

	modport source (output valid, status, hit, slot_valid, slot, write_to_disk,
		evict_writeback, evicted_device, evicted_block, evicted_slot, input ready);
	modport sink (input valid, status, hit, slot_valid, slot, write_to_disk,
		evict_writeback, evicted_device, evicted_block, evicted_slot, output ready);
endinterface

interface bbcwd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bbcwd_pkg::CFG_IDX_W-1:0] index;
	logic                            data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/bbcwd_cell.sv
// one position of the order list: slot, tag, dirty flag and tag compare
module bbcwd_cell #(
	parameter int SLOT_W = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmp_en,
	input  logic [bbcwd_pkg::DEV_W-1:0] req_dev,
	input  logic [bbcwd_pkg::BLK_W-1:0] req_blk,
	input  bbcwd_pkg::cell_cmd_t        cmd,
	input  logic                        load_tail,
	input  logic [SLOT_W-1:0]           load_slot,
	input  bbcwd_pkg::entry_t           load_entry,
	input  logic                        next_valid,
	input  logic [SLOT_W-1:0]           next_slot,
	input  bbcwd_pkg::entry_t           next_entry,
	input  logic                        seen_in,
	output logic                        seen_out,
	output logic                        valid,
	output logic [SLOT_W-1:0]           slot,
	output bbcwd_pkg::entry_t           entry,
	output logic                        match,
	output logic [SLOT_W-1:0]           hit_slot
);

	logic                valid_q;
	logic                match_q;
	logic [SLOT_W-1:0]   slot_q;
	bbcwd_pkg::entry_t   entry_q;
	logic                seen_here;
	logic                load_here;
	logic                shift_here;

	// seen marks this position and all later ones once the hit or head is passed
	assign seen_here  = seen_in | match_q;
	assign seen_out   = seen_here;
	assign load_here  = load_tail | (cmd.load_match & match_q);
	assign shift_here = cmd.shift & seen_here & next_valid & ~load_here;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (cmp_en)
				match_q <= valid_q && (entry_q.dev == req_dev) && (entry_q.blk == req_blk);
			if (load_here)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_here) begin
			slot_q  <= load_slot;
			entry_q <= load_entry;
		end else if (shift_here) begin
			slot_q  <= next_slot;
			entry_q <= next_entry;
		end
	end

	assign valid    = valid_q;
	assign slot     = slot_q;
	assign entry    = entry_q;
	assign match    = match_q;
	assign hit_slot = match_q ? slot_q : '0;

endmodule

// File: design/block_buffer_cache_write_directory_unit.sv
// Write-request directory of a fully associative block buffer cache with NBUF slots. The order
// list is a row of NBUF cells, oldest entry at cell 0; each cell holds a slot number, its device
// and block tag and a dirty flag. A request passes the compare state, where every cell compares
// its tag against the request, then the update state, where the hit, allocation or eviction is
// resolved; where an entry moves to the tail, the cells behind it shift one place toward the
// head. The update waits while the response register is full. A new request can be taken in
// the update state of the previous one, while the response register is free. The register
// write port is always ready; registers should be written only while no request is in flight.
module block_buffer_cache_write_directory_unit #(
	parameter int NBUF = 16
) (
	input  logic clk,
	input  logic arst_n,
	bbcwd_req_if.sink   req,
	bbcwd_rsp_if.source rsp,
	bbcwd_cfg_if.sink   cfg
);

	localparam int SLOT_W = (NBUF > 1) ? $clog2(NBUF) : 1;
	localparam int CNT_W  = $clog2(NBUF + 1);
	localparam logic [CNT_W-1:0] NBUF_CNT = CNT_W'(NBUF);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                  state_q;
	logic [bbcwd_pkg::DEV_W-1:0] req_dev_q;
	logic [bbcwd_pkg::BLK_W-1:0] req_blk_q;
	logic                        write_policy_q;
	logic                        replace_policy_q;
	logic                        cache_closed_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [CNT_W-1:0]            free_q;
	logic                        rsp_valid_q;
	bbcwd_pkg::rsp_t             rsp_q;

	logic                        finish;
	logic                        do_upd;
	logic                        req_xfer;
	bbcwd_pkg::rsp_t             res;
	bbcwd_pkg::cell_cmd_t        cmd;
	logic                        tail_en;
	logic [CNT_W-1:0]            tail_idx;
	logic [SLOT_W-1:0]           tail_slot;
	bbcwd_pkg::entry_t           tail_entry;
	logic                        seen_head;
	logic                        alloc;
	logic                        any_hit;
	logic [SLOT_W-1:0]           hit_slot_or;

	logic                        cell_valid [0:NBUF];
	logic [SLOT_W-1:0]           cell_slot  [0:NBUF];
	bbcwd_pkg::entry_t           cell_entry [0:NBUF];
	logic                        seen       [0:NBUF];
	logic [SLOT_W-1:0]           cell_hit_slot [NBUF];
	logic [NBUF-1:0]             cell_match;
	logic [NBUF-1:0]             load_tail;

	assign finish   = !rsp_valid_q || rsp.ready;
	assign do_upd   = (state_q == ST_UPD) && finish;
	assign req.ready = (state_q == ST_IDLE) || do_upd;
	assign req_xfer = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_policy_q   <= 1'b0;
			replace_policy_q <= 1'b0;
			cache_closed_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				bbcwd_pkg::REG_WRITE_POLICY:   write_policy_q   <= cfg.data;
				bbcwd_pkg::REG_REPLACE_POLICY: replace_policy_q <= cfg.data;
				bbcwd_pkg::REG_CACHE_CLOSED:   cache_closed_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (req_xfer) state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_UPD;
				ST_UPD: begin
					if (req_xfer)
						state_q <= ST_CMP;
					else if (finish)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_dev_q <= req.device_id;
			req_blk_q <= req.block_number;
		end
	end

	// hit slot: at most one cell matches since tags are unique in the list
	always_comb begin
		hit_slot_or = '0;
		for (int i = 0; i < NBUF; i++)
			hit_slot_or = hit_slot_or | cell_hit_slot[i];
	end
	assign any_hit = |cell_match;

	always_comb begin
		res        = '0;
		cmd        = '0;
		tail_en    = 1'b0;
		tail_idx   = cnt_q - CNT_W'(1);
		tail_slot  = cell_slot[0];
		seen_head  = 1'b0;
		alloc      = 1'b0;
		tail_entry.dev   = req_dev_q;
		tail_entry.blk   = req_blk_q;
		tail_entry.dirty = 1'b1;
		if (cache_closed_q) begin
			res.status = bbcwd_pkg::STATUS_CLOSED;
		end else if (any_hit) begin
			res.hit           = 1'b1;
			res.slot_valid    = 1'b1;
			res.slot          = bbcwd_pkg::OUT_SLOT_W'(hit_slot_or);
			res.write_to_disk = !write_policy_q;
			tail_entry.dirty  = write_policy_q;
			tail_slot         = hit_slot_or;
			if (replace_policy_q) begin
				cmd.shift = 1'b1;
				tail_en   = 1'b1;
			end else begin
				cmd.load_match = 1'b1;
			end
		end else if (!write_policy_q) begin
			res.write_to_disk = 1'b1;
		end else if ((free_q != '0) && (cnt_q < NBUF_CNT)) begin
			alloc          = 1'b1;
			tail_en        = 1'b1;
			tail_idx       = cnt_q;
			tail_slot      = SLOT_W'(NBUF_CNT - free_q);
			res.slot_valid = 1'b1;
			res.slot       = bbcwd_pkg::OUT_SLOT_W'(tail_slot);
		end else if (cnt_q < CNT_W'(2)) begin
			res.status = bbcwd_pkg::STATUS_NO_VICTIM;
		end else begin
			// evict the head and reuse its slot at the tail
			seen_head      = 1'b1;
			cmd.shift      = 1'b1;
			tail_en        = 1'b1;
			res.slot_valid = 1'b1;
			res.slot       = bbcwd_pkg::OUT_SLOT_W'(cell_slot[0]);
			if (cell_entry[0].dirty) begin
				res.evict_writeback = 1'b1;
				res.evicted_device  = cell_entry[0].dev;
				res.evicted_block   = cell_entry[0].blk;
				res.evicted_slot    = bbcwd_pkg::OUT_SLOT_W'(cell_slot[0]);
			end
		end
		if (!do_upd) begin
			cmd     = '0;
			tail_en = 1'b0;
			alloc   = 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < NBUF; i++)
			load_tail[i] = tail_en && (tail_idx == CNT_W'(i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			free_q <= NBUF_CNT;
		end else if (alloc) begin
			cnt_q  <= cnt_q + CNT_W'(1);
			free_q <= free_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (do_upd) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_upd)
			rsp_q <= res;
	end

	assign cell_valid[NBUF] = 1'b0;
	assign cell_slot[NBUF]  = '0;
	assign cell_entry[NBUF] = '0;
	assign seen[0]          = seen_head;

	for (genvar g = 0; g < NBUF; g++) begin : g_cell
		bbcwd_cell #(
			.SLOT_W(SLOT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmp_en     (state_q == ST_CMP),
			.req_dev    (req_dev_q),
			.req_blk    (req_blk_q),
			.cmd        (cmd),
			.load_tail  (load_tail[g]),
			.load_slot  (tail_slot),
			.load_entry (tail_entry),
			.next_valid (cell_valid[g+1]),
			.next_slot  (cell_slot[g+1]),
			.next_entry (cell_entry[g+1]),
			.seen_in    (seen[g]),
			.seen_out   (seen[g+1]),
			.valid      (cell_valid[g]),
			.slot       (cell_slot[g]),
			.entry      (cell_entry[g]),
			.match      (cell_match[g]),
			.hit_slot   (cell_hit_slot[g])
		);
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_q.status;
	assign rsp.hit             = rsp_q.hit;
	assign rsp.slot_valid      = rsp_q.slot_valid;
	assign rsp.slot            = rsp_q.slot;
	assign rsp.write_to_disk   = rsp_q.write_to_disk;
	assign rsp.evict_writeback = rsp_q.evict_writeback;
	assign rsp.evicted_device  = rsp_q.evicted_device;
	assign rsp.evicted_block   = rsp_q.evicted_block;
	assign rsp.evicted_slot    = rsp_q.evicted_slot;

endmodule
